@@ sv/pns_pkg.sv @@
// polyline nearest segment: shared types, constants and opcode names
// no dependencies
package pns_pkg;
   localparam int MaxVertices = 256;
   localparam int FracBits    = 16;
   localparam int AddrW       = $clog2(MaxVertices);
   localparam int CountW      = AddrW + 1;
   localparam int CoordW      = 16;
   localparam int VertexW     = 3 * CoordW;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DROPPED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRIME,
      S_SCAN,
      S_DRAIN
   } state_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } vertex_type;

   // one segment handed to the distance pipeline
   typedef struct packed {
      logic       valid;
      logic       first;
      logic       last;
      logic [7:0] index;
   } seg_ctl_type;
endpackage

@@ sv/pns_if.sv @@
// valid/ready channel carrying one beat of payload
// depends on nothing
interface pns_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;
   modport source (output valid, operation, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, operation, coord_x, coord_y, coord_z, output ready);
endinterface

interface pns_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  segment_index;
   logic [35:0] squared_distance;
   logic [1:0]  status;
   modport source (output valid, segment_index, squared_distance, status, input ready);
   modport sink   (input valid, segment_index, squared_distance, status, output ready);
endinterface

@@ sv/polyline_nearest_segment.sv @@
// a query streams the stored vertices out of the vertex ram read port, one segment entering the
// distance pipeline per cycle.
// one query at a time: ready stays low until the query's response has been taken.
// reset: synchronous, clears vertex count, dropped flag, pipeline valids and the
// sequencer; ram contents are undefined until written.
// depends on pns_pkg, pns_if, pns_ram, pns_seg
module polyline_nearest_segment (
   input logic clock,
   input logic reset,
   pns_req_if.sink   req,
   pns_rsp_if.source rsp
);
   import pns_pkg::*;

   state_type state_ff, state_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              drop_ff, drop_in;
   vertex_type        pt_ff;
   logic [CountW-1:0] rd_ptr_ff, rd_ptr_in;
   vertex_type        prev_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_idx_ff;
   logic [35:0]       rsp_dist_ff;
   logic [1:0]        rsp_st_ff;

   logic accept;
   op_type op;
   vertex_type vin, rd_data;
   logic wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic seg_done;
   logic [7:0] best_idx;
   logic [35:0] best_dist;
   seg_ctl_type ctl;
   logic rd_vld_ff;
   logic [CountW-1:0] rd_idx_ff;

   assign op  = op_type'(req.operation);
   assign vin = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req.valid && req.ready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      if (accept && op == OP_START) wr_en = 1'b1;
      else if (accept && op == OP_APPEND && count_ff < CountW'(MaxVertices)) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AddrW-1:0];
      end
   end

   assign rd_addr = rd_ptr_ff[AddrW-1:0];

   pns_ram #(.Width(VertexW), .Depth(MaxVertices)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(vin),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && op == OP_QUERY && count_ff >= CountW'(2)) state_in = S_SCAN;
         S_PRIME: state_in = S_SCAN;
         S_SCAN:  if (rd_ptr_ff == count_ff - CountW'(1)) state_in = S_DRAIN;
         S_DRAIN: if (seg_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      count_in     = count_ff;
      drop_in      = drop_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept) begin
         unique case (op)
            OP_START: begin
               count_in = CountW'(1);
               drop_in  = 1'b0;
            end
            OP_APPEND: begin
               if (count_ff < CountW'(MaxVertices)) count_in = count_ff + CountW'(1);
               else drop_in = 1'b1;
            end
            OP_QUERY: begin
               rd_ptr_in = '0;
               if (count_ff < CountW'(2)) rsp_valid_in = 1'b1;
            end
            default: ;
         endcase
      end
      if (state_ff == S_SCAN && rd_ptr_ff != count_ff - CountW'(1))
         rd_ptr_in = rd_ptr_ff + CountW'(1);
      if (state_ff == S_DRAIN && seg_done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= (state_ff == S_SCAN);
      end
      rd_ptr_ff <= rd_ptr_in;
      rd_idx_ff <= rd_ptr_ff;
      if (accept && op == OP_QUERY) pt_ff <= vin;
      if (rd_vld_ff) prev_ff <= rd_data;
      if (accept && op == OP_QUERY && count_ff < CountW'(2)) begin
         rsp_idx_ff  <= '0;
         rsp_dist_ff <= '0;
         rsp_st_ff   <= ST_SHORT;
      end else if (state_ff == S_DRAIN && seg_done) begin
         rsp_idx_ff  <= best_idx;
         rsp_dist_ff <= best_dist;
         rsp_st_ff   <= drop_ff ? ST_DROPPED : ST_OK;
      end
   end

   // a segment starts once the second vertex of a pair is read back
   always_comb begin
      ctl.valid = rd_vld_ff && rd_idx_ff != '0;
      ctl.first = rd_idx_ff == CountW'(1);
      ctl.last  = rd_vld_ff && rd_idx_ff == count_ff - CountW'(1);
      ctl.index = 8'(rd_idx_ff - CountW'(1));
   end

   pns_seg u_seg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .pt        (pt_ff),
      .va        (prev_ff),
      .vb        (rd_data),
      .done      (seg_done),
      .best_index(best_idx),
      .best_dist (best_dist)
   );

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.segment_index    = rsp_idx_ff;
   assign rsp.squared_distance = rsp_dist_ff;
   assign rsp.status           = rsp_st_ff;

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxVertices)) else $error("count overflow");
   a_no_scan_short: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> count_ff >= CountW'(2)) else $error("scan short");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
endmodule

@@ sv/pns_ram.sv @@
// generic single-port-write, one-read synchronous ram, registered read
// no dependencies
module pns_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ sv/pns_seg.sv @@
// pipelined squared distance from a point to one segment, plus running minimum
// depends on pns_pkg
module pns_seg (
   input  logic                 clock,
   input  logic                 reset,
   input  pns_pkg::seg_ctl_type ctl,
   input  pns_pkg::vertex_type  pt,
   input  pns_pkg::vertex_type  va,
   input  pns_pkg::vertex_type  vb,
   output logic                 done,
   output logic [7:0]           best_index,
   output logic [35:0]          best_dist
);
   import pns_pkg::*;

   localparam int DW  = CoordW + 1;       // differences
   localparam int PW  = 2 * DW;           // products
   localparam int SW  = PW + 2;           // sums of three
   localparam int TW  = FracBits + 1;     // t with one integer bit
   localparam int TDW = DW + TW + 1;

   // stage 1: differences
   seg_ctl_type c1_ff;
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] w1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) c1_ff <= '0; else c1_ff <= ctl;
      d1_ff[0] <= DW'(vb.x) - DW'(va.x);
      d1_ff[1] <= DW'(vb.y) - DW'(va.y);
      d1_ff[2] <= DW'(vb.z) - DW'(va.z);
      w1_ff[0] <= DW'(pt.x) - DW'(va.x);
      w1_ff[1] <= DW'(pt.y) - DW'(va.y);
      w1_ff[2] <= DW'(pt.z) - DW'(va.z);
   end

   // stage 2: products
   seg_ctl_type c2_ff;
   logic signed [DW-1:0] d2_ff [3];
   logic signed [DW-1:0] w2_ff [3];
   logic signed [PW-1:0] wd2_ff [3];
   logic signed [PW-1:0] dd2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) c2_ff <= '0; else c2_ff <= c1_ff;
      for (int k = 0; k < 3; k++) begin
         d2_ff[k]  <= d1_ff[k];
         w2_ff[k]  <= w1_ff[k];
         wd2_ff[k] <= w1_ff[k] * d1_ff[k];
         dd2_ff[k] <= d1_ff[k] * d1_ff[k];
      end
   end

   // stage 3: sums
   seg_ctl_type c3_ff;
   logic signed [DW-1:0] d3_ff [3];
   logic signed [DW-1:0] w3_ff [3];
   logic signed [SW-1:0] dot3_ff, dd3_ff;
   always_ff @(posedge clock) begin
      if (reset) c3_ff <= '0; else c3_ff <= c2_ff;
      d3_ff   <= d2_ff;
      w3_ff   <= w2_ff;
      dot3_ff <= SW'(wd2_ff[0]) + SW'(wd2_ff[1]) + SW'(wd2_ff[2]);
      dd3_ff  <= SW'(dd2_ff[0]) + SW'(dd2_ff[1]) + SW'(dd2_ff[2]);
   end

   // stages 4..: restoring division, one quotient bit per stage (t is below 1 here)
   localparam int NS = FracBits;
   seg_ctl_type          cq_ff [NS+1];
   logic signed [DW-1:0] dq_ff [NS+1][3];
   logic signed [DW-1:0] wq_ff [NS+1][3];
   logic [SW-1:0]        rem_ff [NS+1];
   logic [SW-1:0]        den_ff [NS+1];
   logic [TW-1:0]        t_ff [NS+1];
   logic                 sat_ff [NS+1];

   always_ff @(posedge clock) begin
      if (reset) cq_ff[0] <= '0; else cq_ff[0] <= c3_ff;
      dq_ff[0]  <= d3_ff;
      wq_ff[0]  <= w3_ff;
      den_ff[0] <= dd3_ff;
      t_ff[0]   <= '0;
      if (dd3_ff == '0 || dot3_ff <= 0) begin
         rem_ff[0] <= '0;
         sat_ff[0] <= 1'b0;
      end else if (dot3_ff >= dd3_ff) begin
         rem_ff[0] <= '0;
         sat_ff[0] <= 1'b1;
      end else begin
         rem_ff[0] <= dot3_ff;
         sat_ff[0] <= 1'b0;
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_div
      logic [SW:0] sh;
      assign sh = {rem_ff[s], 1'b0};
      always_ff @(posedge clock) begin
         if (reset) cq_ff[s+1] <= '0; else cq_ff[s+1] <= cq_ff[s];
         dq_ff[s+1]  <= dq_ff[s];
         wq_ff[s+1]  <= wq_ff[s];
         den_ff[s+1] <= den_ff[s];
         sat_ff[s+1] <= sat_ff[s];
         if (sh >= {1'b0, den_ff[s]}) begin
            rem_ff[s+1] <= SW'(sh - {1'b0, den_ff[s]});
            t_ff[s+1]   <= {t_ff[s][TW-2:0], 1'b1};
         end else begin
            rem_ff[s+1] <= SW'(sh);
            t_ff[s+1]   <= {t_ff[s][TW-2:0], 1'b0};
         end
      end
   end

   // t times d, then floor shift
   logic [TW-1:0] t_fin;
   assign t_fin = sat_ff[NS] ? TW'(1 << FracBits) : t_ff[NS];

   seg_ctl_type           cm_ff;
   logic signed [DW-1:0]  wm_ff [3];
   logic signed [TDW-1:0] td_ff [3];
   always_ff @(posedge clock) begin
      if (reset) cm_ff <= '0; else cm_ff <= cq_ff[NS];
      wm_ff <= wq_ff[NS];
      for (int k = 0; k < 3; k++)
         td_ff[k] <= $signed({1'b0, t_fin}) * dq_ff[NS][k];
   end

   // offset
   seg_ctl_type          co_ff;
   logic signed [DW:0]   off_ff [3];
   always_ff @(posedge clock) begin
      if (reset) co_ff <= '0; else co_ff <= cm_ff;
      for (int k = 0; k < 3; k++)
         off_ff[k] <= (DW+1)'(wm_ff[k]) - (DW+1)'(td_ff[k] >>> FracBits);
   end

   // squares, full width product of the signed offsets
   seg_ctl_type              cs_ff;
   logic [2*DW+1:0]          sq_ff [3];
   logic signed [2*DW+1:0]   sq_s [3];
   always_comb begin
      for (int k = 0; k < 3; k++)
         sq_s[k] = off_ff[k] * off_ff[k];
   end
   always_ff @(posedge clock) begin
      if (reset) cs_ff <= '0; else cs_ff <= co_ff;
      for (int k = 0; k < 3; k++)
         sq_ff[k] <= $unsigned(sq_s[k]);
   end

   // sum and running minimum, first wins ties
   logic [35:0] sum;
   assign sum = 36'(sq_ff[0]) + 36'(sq_ff[1]) + 36'(sq_ff[2]);

   logic [35:0] best_ff;
   logic [7:0]  idx_ff;
   logic        done_ff;
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= cs_ff.valid && cs_ff.last;
      if (cs_ff.valid && (cs_ff.first || sum < best_ff)) begin
         best_ff <= sum;
         idx_ff  <= cs_ff.index;
      end
   end

   assign done       = done_ff;
   assign best_index = idx_ff;
   assign best_dist  = best_ff;

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      cs_ff.last |-> cs_ff.valid) else $error("last without valid");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_sat_t: assert property (@(posedge clock) disable iff (reset)
      cq_ff[NS].valid && sat_ff[NS] |-> t_ff[NS] == '0) else $error("sat with t");
endmodule
